[rtl/keyed_fifo_queue_defines.svh]
// Assertion macros shared by the keyed FIFO queue RTL.
`ifndef KEYED_FIFO_QUEUE_DEFINES_SVH
`define KEYED_FIFO_QUEUE_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define KFQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define KFQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/kfq_pkg.sv]
// Shared types and constants of the keyed FIFO queue.
package kfq_pkg;

   // Fixed field widths of the stream payloads.
   localparam int FUNC_W      = 3;
   localparam int FIELD_W     = 32;
   localparam int STATUS_W    = 3;
   localparam int COUNT_W     = 5;
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 136;

   // Default configuration.
   localparam int DEPTH_DEF     = 16;
   localparam int KEY_BITS_DEF  = 32;
   localparam int DATA_BITS_DEF = 32;

   // Entries of the command queue between front and back; a power of two.
   localparam int CMD_QDEPTH = 2;

   // Operation codes as they arrive on the request channel.
   localparam logic [FUNC_W-1:0] FUNC_ENQ   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_DEQ   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_PEEK  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_CHG   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd4;

   // Status codes of a response.
   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUP     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_MISSING = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

   // Classified operation handed from front to back.
   typedef enum logic [2:0] {
      OP_ENQ,
      OP_DEQ,
      OP_PEEK,
      OP_CHG,
      OP_CLEAR,
      OP_NOP
   } op_type;

endpackage

[rtl/kfq_front.sv]
// Request front end: decodes each request and buffers it in a short command queue.
module kfq_front
   import kfq_pkg::*;
#(
   parameter int KEY_BITS  = KEY_BITS_DEF,
   parameter int DATA_BITS = DATA_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [FUNC_W-1:0]      req_tuser,
   output logic                   cmd_valid,
   input  logic                   cmd_ready,
   output op_type                 cmd_op,
   output logic [KEY_BITS-1:0]    cmd_key,
   output logic [DATA_BITS-1:0]   cmd_data
);

   localparam int QIDX_W = (CMD_QDEPTH > 1) ? $clog2(CMD_QDEPTH) : 1;
   localparam int FILL_W = $clog2(CMD_QDEPTH + 1);

   op_type                op_dec;
   logic [KEY_BITS-1:0]   key_dec;
   logic [DATA_BITS-1:0]  data_dec;
   op_type                q_op_ff   [CMD_QDEPTH];
   logic [KEY_BITS-1:0]   q_key_ff  [CMD_QDEPTH];
   logic [DATA_BITS-1:0]  q_data_ff [CMD_QDEPTH];
   logic [QIDX_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QIDX_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic                  push, pop;

   always_comb begin
      case (req_tuser)
         FUNC_ENQ:   op_dec = OP_ENQ;
         FUNC_DEQ:   op_dec = OP_DEQ;
         FUNC_PEEK:  op_dec = OP_PEEK;
         FUNC_CHG:   op_dec = OP_CHG;
         FUNC_CLEAR: op_dec = OP_CLEAR;
         default:    op_dec = OP_NOP;
      endcase
   end

   // Keys and data are signed; they are sign-extended or cut to the stored width.
   assign key_dec  = KEY_BITS'(signed'(req_tdata[FIELD_W-1:0]));
   assign data_dec = DATA_BITS'(signed'(req_tdata[2*FIELD_W-1:FIELD_W]));

   assign req_tready = (fill_ff != FILL_W'(CMD_QDEPTH));
   assign cmd_valid  = (fill_ff != '0);
   assign push       = req_tvalid && req_tready;
   assign pop        = cmd_valid && cmd_ready;

   assign cmd_op   = q_op_ff[rd_ptr_ff];
   assign cmd_key  = q_key_ff[rd_ptr_ff];
   assign cmd_data = q_data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_op_ff[wr_ptr_ff]   <= op_dec;
         q_key_ff[wr_ptr_ff]  <= key_dec;
         q_data_ff[wr_ptr_ff] <= data_dec;
      end
   end

endmodule

[rtl/kfq_back.sv]
// Execution back end: the ring of key and data entries, the key scan and the response register.
module kfq_back
   import kfq_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int KEY_BITS  = KEY_BITS_DEF,
   parameter int DATA_BITS = DATA_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   cmd_ready,
   input  op_type                 cmd_op,
   input  logic [KEY_BITS-1:0]    cmd_key,
   input  logic [DATA_BITS-1:0]   cmd_data,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [STATUS_W-1:0]    rsp_tuser
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DEQ,
      S_PEEK,
      S_RESP
   } state_type;

   function automatic logic [IDX_W-1:0] next_pos(input logic [IDX_W-1:0] p);
      next_pos = (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   logic [KEY_BITS-1:0]  key_mem  [DEPTH];
   logic [DATA_BITS-1:0] data_mem [DEPTH];

   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [DATA_BITS-1:0] data_ff, data_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [IDX_W-1:0]     tail_ff, tail_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [KEY_BITS-1:0]  front_key_ff, front_key_in;
   logic [KEY_BITS-1:0]  rear_key_ff, rear_key_in;
   logic [IDX_W-1:0]     scan_pos_ff, scan_pos_in;
   logic [CNT_W-1:0]     scan_cnt_ff, scan_cnt_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]     cmp_pos_ff, cmp_pos_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [KEY_BITS-1:0]  res_key_ff, res_key_in;
   logic [DATA_BITS-1:0] res_data_ff, res_data_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [FIELD_W-1:0]   rsp_out_key_ff, rsp_out_key_in;
   logic [FIELD_W-1:0]   rsp_out_data_ff, rsp_out_data_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_empty_ff, rsp_empty_in;
   logic [FIELD_W-1:0]   rsp_front_ff, rsp_front_in;
   logic [FIELD_W-1:0]   rsp_rear_ff, rsp_rear_in;

   logic [KEY_BITS-1:0]  key_rd_ff;
   logic [DATA_BITS-1:0] data_rd_ff;
   logic [IDX_W-1:0]     key_raddr, data_raddr;
   logic                 key_we, data_we;
   logic [IDX_W-1:0]     key_waddr, data_waddr;
   logic [DATA_BITS-1:0] data_wdata;

   logic                 slot_free, hit, issue, miss, full, empty;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign cmd_ready = (state_ff == S_IDLE) && slot_free;
   assign hit       = cmp_vld_ff && (key_rd_ff == key_ff);
   assign issue     = (scan_cnt_ff != count_ff);
   assign miss      = !cmp_vld_ff && !issue;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      key_in          = key_ff;
      data_in         = data_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      count_in        = count_ff;
      front_key_in    = front_key_ff;
      rear_key_in     = rear_key_ff;
      scan_pos_in     = scan_pos_ff;
      scan_cnt_in     = scan_cnt_ff;
      cmp_vld_in      = 1'b0;
      cmp_pos_in      = cmp_pos_ff;
      res_status_in   = res_status_ff;
      res_key_in      = res_key_ff;
      res_data_in     = res_data_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_status_in   = rsp_status_ff;
      rsp_out_key_in  = rsp_out_key_ff;
      rsp_out_data_in = rsp_out_data_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_empty_in    = rsp_empty_ff;
      rsp_front_in    = rsp_front_ff;
      rsp_rear_in     = rsp_rear_ff;
      key_raddr       = scan_pos_ff;
      data_raddr      = cmp_pos_ff;
      key_we          = 1'b0;
      key_waddr       = tail_ff;
      data_we         = 1'b0;
      data_waddr      = tail_ff;
      data_wdata      = data_ff;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && slot_free) begin
               op_in         = cmd_op;
               key_in        = cmd_key;
               data_in       = cmd_data;
               res_status_in = ST_OK;
               res_key_in    = '0;
               res_data_in   = '0;
               scan_pos_in   = head_ff;
               scan_cnt_in   = '0;
               case (cmd_op)
                  OP_ENQ, OP_PEEK, OP_CHG: begin
                     state_in = S_SCAN;
                  end
                  OP_DEQ: begin
                     if (empty) begin
                        res_status_in = ST_EMPTY;
                        state_in      = S_RESP;
                     end else begin
                        // The front key is already held; fetch the one behind it.
                        key_raddr  = next_pos(head_ff);
                        data_raddr = head_ff;
                        state_in   = S_DEQ;
                     end
                  end
                  OP_CLEAR: begin
                     head_in  = '0;
                     tail_in  = '0;
                     count_in = '0;
                     state_in = S_RESP;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // Reads are issued one per cycle and compared in the following cycle.
            if (issue) begin
               key_raddr   = scan_pos_ff;
               scan_pos_in = next_pos(scan_pos_ff);
               scan_cnt_in = scan_cnt_ff + 1'b1;
               cmp_pos_in  = scan_pos_ff;
               cmp_vld_in  = 1'b1;
            end
            if (hit) begin
               case (op_ff)
                  OP_ENQ: begin
                     res_status_in = ST_DUP;
                     state_in      = S_RESP;
                  end
                  OP_PEEK: begin
                     data_raddr = cmp_pos_ff;
                     state_in   = S_PEEK;
                  end
                  default: begin
                     data_we    = 1'b1;
                     data_waddr = cmp_pos_ff;
                     data_wdata = data_ff;
                     state_in   = S_RESP;
                  end
               endcase
            end else if (miss) begin
               state_in = S_RESP;
               if (op_ff == OP_ENQ) begin
                  if (full) begin
                     res_status_in = ST_FULL;
                  end else begin
                     key_we      = 1'b1;
                     key_waddr   = tail_ff;
                     data_we     = 1'b1;
                     data_waddr  = tail_ff;
                     data_wdata  = data_ff;
                     tail_in     = next_pos(tail_ff);
                     count_in    = count_ff + 1'b1;
                     rear_key_in = key_ff;
                     if (empty) begin
                        front_key_in = key_ff;
                     end
                  end
               end else begin
                  res_status_in = ST_MISSING;
               end
            end
         end

         S_DEQ: begin
            res_key_in   = front_key_ff;
            res_data_in  = data_rd_ff;
            front_key_in = key_rd_ff;
            head_in      = next_pos(head_ff);
            count_in     = count_ff - 1'b1;
            state_in     = S_RESP;
         end

         S_PEEK: begin
            res_data_in = data_rd_ff;
            state_in    = S_RESP;
         end

         S_RESP: begin
            rsp_valid_in    = 1'b1;
            rsp_status_in   = res_status_ff;
            rsp_out_key_in  = FIELD_W'(signed'(res_key_ff));
            rsp_out_data_in = FIELD_W'(signed'(res_data_ff));
            rsp_count_in    = COUNT_W'(count_ff);
            rsp_empty_in    = empty;
            rsp_front_in    = empty ? '0 : FIELD_W'(signed'(front_key_ff));
            rsp_rear_in     = empty ? '0 : FIELD_W'(signed'(rear_key_ff));
            state_in        = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         op_ff           <= op_in;
         key_ff          <= key_in;
         data_ff         <= data_in;
         head_ff         <= head_in;
         tail_ff         <= tail_in;
         count_ff        <= count_in;
         front_key_ff    <= front_key_in;
         rear_key_ff     <= rear_key_in;
         scan_pos_ff     <= scan_pos_in;
         scan_cnt_ff     <= scan_cnt_in;
         cmp_vld_ff      <= cmp_vld_in;
         cmp_pos_ff      <= cmp_pos_in;
         res_status_ff   <= res_status_in;
         res_key_ff      <= res_key_in;
         res_data_ff     <= res_data_in;
         rsp_valid_ff    <= rsp_valid_in;
         rsp_status_ff   <= rsp_status_in;
         rsp_out_key_ff  <= rsp_out_key_in;
         rsp_out_data_ff <= rsp_out_data_in;
         rsp_count_ff    <= rsp_count_in;
         rsp_empty_ff    <= rsp_empty_in;
         rsp_front_ff    <= rsp_front_in;
         rsp_rear_ff     <= rsp_rear_in;
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= key_ff;
      end
      key_rd_ff <= key_mem[key_raddr];
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[data_waddr] <= data_wdata;
      end
      data_rd_ff <= data_mem[data_raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_rear_ff, rsp_front_ff, rsp_empty_ff, rsp_count_ff,
                        rsp_out_data_ff, rsp_out_key_ff};

endmodule

[rtl/keyed_fifo_queue.sv]
// Top level of the keyed FIFO queue: request decoder, command queue and execution back end.
//
//   Channel  Direction  Payload
//   req_*    in         tuser: func; tdata: in_key, in_data
//   rsp_*    out        tuser: status; tdata: out_key, out_data, item_count,
//                       queue_empty, front_key, rear_key
//
// Requests are decoded and held in a two-entry command queue, so a new request
// transaction is taken while an earlier one executes or its response waits.
// Dequeue passes through a read state before the response state; clear and unused
// codes go straight to the response state. Enqueue, peek and change last as long as
// the key scan, which reads one entry per cycle through the key memory's read port.
// Reset clears the state, the ring pointers, the count and the valid flags; entry
// storage is never swept. The response register holds its transaction while rsp_tready is low.
`include "keyed_fifo_queue_defines.svh"

module keyed_fifo_queue
   import kfq_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int KEY_BITS  = KEY_BITS_DEF,
   parameter int DATA_BITS = DATA_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [31:0] in_key, [63:32] in_data
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [2:0] func
   input  logic [FUNC_W-1:0]      req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [31:0] out_key, [63:32] out_data, [68:64] item_count, [69] queue_empty,
   // [101:70] front_key, [133:102] rear_key, [135:134] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // [2:0] status
   output logic [STATUS_W-1:0]    rsp_tuser
);

   logic                 cmd_valid;
   logic                 cmd_ready;
   op_type               cmd_op;
   logic [KEY_BITS-1:0]  cmd_key;
   logic [DATA_BITS-1:0] cmd_data;

   // The front end decodes the operation and sign-extends or narrows key and data to the stored width.
   kfq_front #(
      .KEY_BITS  (KEY_BITS),
      .DATA_BITS (DATA_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd_op     (cmd_op),
      .cmd_key    (cmd_key),
      .cmd_data   (cmd_data)
   );

   // The back end owns the ring and takes a command only when it is idle and its response slot is free.
   kfq_back #(
      .DEPTH     (DEPTH),
      .KEY_BITS  (KEY_BITS),
      .DATA_BITS (DATA_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd_op     (cmd_op),
      .cmd_key    (cmd_key),
      .cmd_data   (cmd_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // An empty queue reports a zero count and zero front and rear keys.
   `KFQ_ASSERT_NOW(a_empty_fields, clock, reset, rsp_tvalid && rsp_tdata[69],
                   (rsp_tdata[68:64] == '0) && (rsp_tdata[133:70] == '0),
                   "empty response with stale fields")

   // Only a successful operation returns a key.
   `KFQ_ASSERT_NOW(a_key_only_ok, clock, reset, rsp_tvalid && (rsp_tdata[31:0] != '0),
                   rsp_tuser == ST_OK, "key returned with failing status")

   // Duplicate and full refusals can only happen with entries stored.
   `KFQ_ASSERT_NOW(a_refusal_nonempty, clock, reset,
                   rsp_tvalid && ((rsp_tuser == ST_DUP) || (rsp_tuser == ST_FULL)),
                   !rsp_tdata[69], "refusal reported on an empty queue")

   // Responses are never issued back to back.
   `KFQ_ASSERT_NEXT(a_resp_gap, clock, reset, rsp_tvalid && rsp_tready, !rsp_tvalid,
                    "response issued in the cycle after a transfer")

endmodule
